// File: rtl/core/mfsd_pkg.sv
package mfsd_pkg;

	localparam int DEF_STORE_BYTES = 256;
	localparam int DEF_MAX_PAYLOAD = 240;
	localparam int RESULT_LIMIT    = 64;
	localparam int RES_CNT_W       = 7;
	localparam int CFG_IDX_W       = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEAD_MAGIC = 1'b0,
		REG_TAIL_MAGIC = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		KIND_DESC    = 1'b0,
		KIND_PAYLOAD = 1'b1
	} res_kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SC_RD,
		ST_SC_CAP,
		ST_DROP,
		ST_HD_RD,
		ST_HD_CAP,
		ST_EVAL,
		ST_TL_RD,
		ST_TL_CAP,
		ST_DESC,
		ST_PL_RD,
		ST_PL_CAP,
		ST_PAYW
	} state_t;

endpackage

// File: rtl/core/mfsd_byte_if.sv
interface mfsd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// File: rtl/core/mfsd_res_if.sv
interface mfsd_res_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [31:0] frame_type;
	logic [7:0]  payload_length;
	logic [31:0] payload_word;
	logic [2:0]  word_bytes;
	logic        last_of_frame;

	modport source (output valid, output result_kind, output frame_type,
		output payload_length, output payload_word, output word_bytes,
		output last_of_frame, input ready);
	modport sink (input valid, input result_kind, input frame_type,
		input payload_length, input payload_word, input word_bytes,
		input last_of_frame, output ready);
endinterface

// File: rtl/core/mfsd_cfg_if.sv
interface mfsd_cfg_if
	import mfsd_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/mfsd_ram.sv
module mfsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/magic_framed_stream_deframer_top.sv
// Byte stream deframer: head word, type word, size word, payload, tail word.
// in_ch takes one stream byte per word. out_ch gives per good frame one
// descriptor word (type, length) followed by payload words of up to four
// bytes, the last one marked. cfg_ch writes head_magic (index 0) and
// tail_magic (index 1); it is always ready. The user must use it only
// while idle; the block does not enforce this. Bytes wait in a circular
// byte store (one RAM, single read port, registered read); each byte read
// by the sequencer takes a read state and a capture state. Per input byte,
// once four or more bytes are held, the sequencer rescans for the head
// word; it then parses the type and size words, checks the tail word, and
// for a full frame reads each payload byte, emits each result and drops
// the frame. A frame reject (bad size or tail) drops one byte and rescans.
// in_ch is ready only when the sequencer is idle; a result waiting in the
// output register does not block the next byte. A stalled receiver holds
// the sequencer at its next result unless the result limit is hit. Reset
// empties the store at once (no clearing pass) and zeroes both magic words.
module magic_framed_stream_deframer_top
	import mfsd_pkg::*;
#(
	parameter int STORE_BYTES = DEF_STORE_BYTES,
	parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
	input  logic              clk,
	input  logic              arst_n,
	mfsd_byte_if.sink         in_ch,
	mfsd_res_if.source        out_ch,
	mfsd_cfg_if.sink          cfg_ch
);

	localparam int AW = $clog2(STORE_BYTES);
	localparam int FW = AW + 1;
	localparam int LW = $clog2(MAX_PAYLOAD + 17);
	localparam int CW = (FW > LW) ? FW : LW;

	state_t state_q, state_d;

	logic [AW-1:0]        base_q;
	logic [FW-1:0]        fill_q;
	logic [AW-1:0]        off_q;
	logic [1:0]           k_q;
	logic [31:0]          w_q;
	logic [31:0]          type_q;
	logic [LW-1:0]        size_q;
	logic [LW-1:0]        pay_q;
	logic [FW-1:0]        drop_q;
	logic                 post_scan_q;
	logic [RES_CNT_W-1:0] res_cnt_q;
	logic [31:0]          head_q;
	logic [31:0]          tail_q;

	logic        out_valid_q;
	logic        kind_q;
	logic [31:0] ftype_q;
	logic [7:0]  plen_q;
	logic [31:0] pword_q;
	logic [2:0]  wbytes_q;
	logic        last_q;

	logic          in_fire;
	logic          full;
	logic [7:0]    rd_data;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [31:0]   w_next;
	logic          head_hit;
	logic          scan_end;
	logic [CW-1:0] size_c;
	logic [CW-1:0] fill_c;
	logic [CW-1:0] total_c;
	logic [CW-1:0] eval_total;
	logic [CW-1:0] pl_off;
	logic [LW-1:0] rem;
	logic [2:0]    cnt;
	logic          pl_done;
	logic          size_bad;
	logic [FW-1:0] fill_after;
	logic          slot_free;
	logic          limit_hit;
	logic          emit_ok;
	logic          out_fire;
	logic [31:0]   size32;

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] b, input logic [FW-1:0] x);
		logic [FW-1:0] s;
		s = {1'b0, b} + x;
		if (s >= FW'(STORE_BYTES)) begin
			s = s - FW'(STORE_BYTES);
		end
		return s[AW-1:0];
	endfunction

	// config
	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (cfg_ch.valid) begin
			if (cfg_ch.index == REG_HEAD_MAGIC) begin
				head_q <= cfg_ch.data;
			end else if (cfg_ch.index == REG_TAIL_MAGIC) begin
				tail_q <= cfg_ch.data;
			end
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign full        = (fill_q == FW'(STORE_BYTES));
	assign wr_addr     = wrap_add(base_q, fill_q);

	mfsd_ram #(
		.WIDTH(8),
		.DEPTH(STORE_BYTES)
	) u_store (
		.clk  (clk),
		.we   (in_fire && !full),
		.waddr(wr_addr),
		.wdata(in_ch.rx_byte),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	assign w_next     = {rd_data, w_q[31:8]};
	assign head_hit   = (off_q >= AW'(3)) && (w_next == head_q);
	assign scan_end   = ({1'b0, off_q} == fill_q - FW'(1));
	assign size_c     = CW'(size_q);
	assign fill_c     = CW'(fill_q);
	assign total_c    = size_c + CW'(16);
	assign size_bad   = (w_q > 32'(MAX_PAYLOAD));
	assign eval_total = CW'(w_q[LW-1:0]) + CW'(16);
	assign pl_off     = CW'(12) + CW'(pay_q) + CW'(k_q);
	assign rem        = size_q - pay_q;
	assign cnt        = (rem >= LW'(4)) ? 3'd4 : rem[2:0];
	assign pl_done    = ({1'b0, k_q} + 3'd1) == cnt;
	assign fill_after = fill_q - drop_q;
	assign slot_free  = !out_valid_q || out_ch.ready;
	assign limit_hit  = (res_cnt_q >= RES_CNT_W'(RESULT_LIMIT));
	assign emit_ok    = limit_hit || slot_free;
	assign out_fire   = ((state_q == ST_DESC) || (state_q == ST_PAYW)) && !limit_hit && slot_free;
	assign size32     = 32'(size_q);

	always_comb begin
		rd_addr = wrap_add(base_q, {1'b0, off_q});
		if (state_q == ST_PL_RD) begin
			rd_addr = wrap_add(base_q, pl_off[FW-1:0]);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = full ? ST_IDLE : ST_CHECK;
				end
			end
			ST_CHECK:  state_d = (fill_q >= FW'(4)) ? ST_SC_RD : ST_IDLE;
			ST_SC_RD:  state_d = ST_SC_CAP;
			ST_SC_CAP: state_d = (head_hit || scan_end) ? ST_DROP : ST_SC_RD;
			ST_DROP: begin
				if (post_scan_q) begin
					state_d = (fill_after < FW'(12)) ? ST_IDLE : ST_HD_RD;
				end else begin
					state_d = ST_CHECK;
				end
			end
			ST_HD_RD:  state_d = ST_HD_CAP;
			ST_HD_CAP: state_d = (off_q == AW'(11)) ? ST_EVAL : ST_HD_RD;
			ST_EVAL: begin
				if (size_bad) begin
					state_d = ST_DROP;
				end else if (fill_c < eval_total) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_TL_RD;
				end
			end
			ST_TL_RD: state_d = ST_TL_CAP;
			ST_TL_CAP: begin
				if (k_q == 2'd3) begin
					state_d = (w_next == tail_q) ? ST_DESC : ST_DROP;
				end else begin
					state_d = ST_TL_RD;
				end
			end
			ST_DESC: begin
				if (emit_ok) begin
					state_d = (size_q == '0) ? ST_DROP : ST_PL_RD;
				end
			end
			ST_PL_RD:  state_d = ST_PL_CAP;
			ST_PL_CAP: state_d = pl_done ? ST_PAYW : ST_PL_RD;
			ST_PAYW: begin
				if (emit_ok) begin
					state_d = (rem <= LW'(4)) ? ST_DROP : ST_PL_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			base_q      <= '0;
			fill_q      <= '0;
			res_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			post_scan_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_fire) begin
				out_valid_q <= 1'b1;
				res_cnt_q   <= res_cnt_q + RES_CNT_W'(1);
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						res_cnt_q <= '0;
						fill_q    <= full ? '0 : fill_q + FW'(1);
					end
				end
				ST_CHECK: post_scan_q <= 1'b1;
				ST_DROP: begin
					base_q <= wrap_add(base_q, drop_q);
					fill_q <= fill_after;
				end
				ST_EVAL: begin
					if (size_bad) begin
						post_scan_q <= 1'b0;
					end
				end
				ST_TL_CAP: begin
					if (k_q == 2'd3 && w_next != tail_q) begin
						post_scan_q <= 1'b0;
					end
				end
				ST_DESC, ST_PAYW: begin
					if (emit_ok) begin
						post_scan_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_CHECK: off_q <= '0;
			ST_SC_CAP: begin
				w_q <= w_next;
				if (head_hit) begin
					drop_q <= {1'b0, off_q} - FW'(3);
				end else if (scan_end) begin
					drop_q <= fill_q - FW'(3);
				end else begin
					off_q <= off_q + AW'(1);
				end
			end
			ST_DROP: off_q <= AW'(4);
			ST_HD_CAP: begin
				w_q   <= w_next;
				off_q <= off_q + AW'(1);
				if (off_q == AW'(7)) begin
					type_q <= w_next;
				end
			end
			ST_EVAL: begin
				drop_q <= FW'(1);
				size_q <= w_q[LW-1:0];
				off_q  <= AW'(CW'(12) + CW'(w_q[LW-1:0]));
				k_q    <= '0;
			end
			ST_TL_CAP: begin
				w_q   <= w_next;
				k_q   <= k_q + 2'd1;
				off_q <= off_q + AW'(1);
			end
			ST_DESC, ST_PAYW: begin
				if (emit_ok) begin
					drop_q <= total_c[FW-1:0];
					pay_q  <= (state_q == ST_DESC) ? '0 : pay_q + LW'(4);
					k_q    <= '0;
					w_q    <= '0;
				end
			end
			ST_PL_CAP: begin
				w_q[8*k_q +: 8] <= rd_data;
				k_q             <= k_q + 2'd1;
			end
			default: ;
		endcase
		if (out_fire) begin
			if (state_q == ST_DESC) begin
				kind_q   <= KIND_DESC;
				ftype_q  <= type_q;
				plen_q   <= size32[7:0];
				pword_q  <= '0;
				wbytes_q <= '0;
				last_q   <= (size_q == '0);
			end else begin
				kind_q   <= KIND_PAYLOAD;
				ftype_q  <= '0;
				plen_q   <= '0;
				pword_q  <= w_q;
				wbytes_q <= cnt;
				last_q   <= (rem <= LW'(4));
			end
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.result_kind    = kind_q;
	assign out_ch.frame_type     = ftype_q;
	assign out_ch.payload_length = plen_q;
	assign out_ch.payload_word   = pword_q;
	assign out_ch.word_bytes     = wbytes_q;
	assign out_ch.last_of_frame  = last_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(STORE_BYTES))
		else $error("store fill beyond capacity");

	a_res_limit: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_q <= RES_CNT_W'(RESULT_LIMIT))
		else $error("result count beyond limit");

	a_desc_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == KIND_DESC |-> wbytes_q == 3'd0)
		else $error("descriptor carries payload bytes");

	a_word_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == KIND_PAYLOAD |-> wbytes_q != 3'd0 && wbytes_q <= 3'd4)
		else $error("payload word byte count out of range");

endmodule
